FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the radix digit converter.
// Clock clk and synchronous active-high reset rst are assumed in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk, off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked at every rising edge of clk, also during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/itbd_pkg.sv
// Shared types, widths and the digit character mapping for the radix
// digit converter. No dependencies.
package itbd_pkg;

  localparam int VALUE_W    = 31;
  localparam int BASE_W     = 5;
  localparam int DIGIT_W    = BASE_W - 1;
  localparam int CHAR_W     = 7;
  localparam int MAX_DIGITS = 32;
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int COUNT_W    = IDX_W + 1;
  localparam int STEP_W     = $clog2(VALUE_W);

  localparam logic [BASE_W-1:0]  RADIX_MIN   = BASE_W'(2);
  localparam logic [BASE_W-1:0]  RADIX_MAX   = BASE_W'(16);
  localparam logic [DIGIT_W-1:0] DEC_LIMIT   = DIGIT_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CHAR_LETTER = CHAR_W'(87);

  // Divider status handed to the controller
  typedef struct packed {
    logic               done;
    logic               busy;
    logic [VALUE_W-1:0] quotient;
    logic [DIGIT_W-1:0] remainder;
  } div_status_t;

  // Map a digit to lower-case ASCII: 0-9 then a-f
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = CHAR_W'(d);
    return (d < DEC_LIMIT) ? (CHAR_ZERO + ext) : (CHAR_LETTER + ext);
  endfunction

endpackage

FILE: rtl/int_to_base_digits.sv
// Top level of the radix digit converter; uses itbd_pkg, itbd_divider, itbd_digit_ram.
// Each digit takes one bit-serial divider run (31 quotient bits); all digits
// are divided before the first character is emitted.
// Emission: digit store read, then output word; out_stall holds the word.
// One item at a time; in_stall stays high from acceptance to the last character.
// Reset (rst, synchronous) returns to idle and clears the digit count.
`include "assert_macros.svh"

module int_to_base_digits (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [itbd_pkg::VALUE_W-1:0]  value,
  input  logic [itbd_pkg::BASE_W-1:0]   digit_base,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [itbd_pkg::CHAR_W-1:0]   char_code,
  output logic                          last
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_READ = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                        state;
  logic [itbd_pkg::BASE_W-1:0]   radix;
  logic [itbd_pkg::BASE_W-1:0]   radix_sat;
  logic [itbd_pkg::COUNT_W-1:0]  count;
  logic [itbd_pkg::IDX_W-1:0]    emit_idx;
  logic                          in_accept;
  logic                          out_accept;
  logic                          count_full;
  logic                          div_start;
  logic [itbd_pkg::VALUE_W-1:0]  div_dividend;
  logic [itbd_pkg::BASE_W-1:0]   div_radix;
  itbd_pkg::div_status_t         div_st;
  logic                          wr_en;
  logic                          rd_en;
  logic [itbd_pkg::DIGIT_W-1:0]  rd_data;
  logic                          quot_zero;

  // Clamp the base into 2..16
  always_comb begin
    priority if (digit_base < itbd_pkg::RADIX_MIN) begin
      radix_sat = itbd_pkg::RADIX_MIN;
    end else if (digit_base > itbd_pkg::RADIX_MAX) begin
      radix_sat = itbd_pkg::RADIX_MAX;
    end else begin
      radix_sat = digit_base;
    end
  end

  // Handshakes and divider feed
  always_comb begin
    in_stall     = (state != S_IDLE);
    in_accept    = in_valid && !in_stall;
    out_valid    = (state == S_EMIT);
    out_accept   = out_valid && !out_stall;
    count_full   = (count >= itbd_pkg::COUNT_W'(itbd_pkg::MAX_DIGITS));
    quot_zero    = (div_st.quotient == '0);
    div_start    = in_accept || ((state == S_DIV) && div_st.done && !quot_zero);
    div_dividend = (state == S_IDLE) ? value : div_st.quotient;
    div_radix    = (state == S_IDLE) ? radix_sat : radix;
    wr_en        = (state == S_DIV) && div_st.done && !count_full;
    rd_en        = (state == S_READ);
  end

  itbd_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .radix    (div_radix),
    .status   (div_st)
  );

  itbd_digit_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[itbd_pkg::IDX_W-1:0]),
    .wr_data (div_st.remainder),
    .rd_en   (rd_en),
    .rd_addr (emit_idx),
    .rd_data (rd_data)
  );

  // Sequence: divide digit by digit, then read back and emit top digit first
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      emit_idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            radix <= radix_sat;
            count <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            if (!count_full) begin
              count <= count + itbd_pkg::COUNT_W'(1);
            end
            if (quot_zero) begin
              emit_idx <= count_full ? itbd_pkg::IDX_W'(itbd_pkg::MAX_DIGITS - 1)
                                     : count[itbd_pkg::IDX_W-1:0];
              state    <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_accept) begin
            if (emit_idx == '0) begin
              state <= S_IDLE;
            end else begin
              emit_idx <= emit_idx - itbd_pkg::IDX_W'(1);
              state    <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output word comes straight from the held read data
  assign char_code = itbd_pkg::digit_char(rd_data);
  assign last      = (emit_idx == '0);

  `ASSERT_CLK(a_emit_has_digits, out_valid |-> (count != '0), "emitting with no stored digits")
  `ASSERT_CLK(a_done_in_div, div_st.done |-> (state == S_DIV), "divider finished outside divide phase")
  `ASSERT_CLK(a_start_when_free, div_start |-> !div_st.busy, "divider restarted while busy")
  `ASSERT_CLK(a_last_to_idle, (out_accept && last) |=> !in_stall, "not idle after final character")

endmodule

FILE: rtl/itbd_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on itbd_pkg for widths and the status struct.
module itbd_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [itbd_pkg::VALUE_W-1:0]  dividend,
  input  logic [itbd_pkg::BASE_W-1:0]   radix,
  output itbd_pkg::div_status_t         status
);

  logic [itbd_pkg::VALUE_W-1:0] dvd;
  logic [itbd_pkg::DIGIT_W-1:0] rem;
  logic [itbd_pkg::BASE_W-1:0]  divisor;
  logic [itbd_pkg::STEP_W-1:0]  step;
  logic                         busy;
  logic                         done;
  logic [itbd_pkg::BASE_W-1:0]  trial;
  logic                         fits;
  logic [itbd_pkg::BASE_W-1:0]  diff;

  // Bring down the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, dvd[itbd_pkg::VALUE_W-1]};
    fits  = (trial >= divisor);
    diff  = trial - divisor;
  end

  // Control: count steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + itbd_pkg::STEP_W'(1);
        if (step == itbd_pkg::STEP_W'(itbd_pkg::VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift into the dividend register from the bottom
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      dvd     <= dividend;
      rem     <= '0;
      divisor <= radix;
    end else if (busy) begin
      dvd <= {dvd[itbd_pkg::VALUE_W-2:0], fits};
      rem <= fits ? diff[itbd_pkg::DIGIT_W-1:0] : trial[itbd_pkg::DIGIT_W-1:0];
    end
  end

  assign status.done      = done;
  assign status.busy      = busy;
  assign status.quotient  = dvd;
  assign status.remainder = rem;

endmodule

FILE: rtl/itbd_digit_ram.sv
// Digit store: one write port, one registered read port.
// Depends on itbd_pkg for depth and digit width.
module itbd_digit_ram (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [itbd_pkg::IDX_W-1:0]    wr_addr,
  input  logic [itbd_pkg::DIGIT_W-1:0]  wr_data,
  input  logic                          rd_en,
  input  logic [itbd_pkg::IDX_W-1:0]    rd_addr,
  output logic [itbd_pkg::DIGIT_W-1:0]  rd_data
);

  logic [itbd_pkg::DIGIT_W-1:0] mem [itbd_pkg::MAX_DIGITS];

  // Write a digit
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read a digit, data valid the next cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: bench/int_to_base_digits_checker.sv
// Checker for the radix digit converter: watches both channels, predicts the
// character words of each accepted value and compares them in order.
// Depends on itbd_pkg for field widths and radix limits.
`timescale 1ns / 1ps

module int_to_base_digits_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [itbd_pkg::VALUE_W-1:0]  value,
  input  logic [itbd_pkg::BASE_W-1:0]   digit_base,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [itbd_pkg::CHAR_W-1:0]   char_code,
  input  logic                          last,
  output int                            fail_count,
  output int                            pending,
  output int                            values_seen,
  output int                            chars_seen
);
  import itbd_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              tail;
  } char_word_t;

  // Characters still owed by the block, oldest first
  char_word_t expected_chars[$];

  initial begin
    fail_count  = 0;
    pending     = 0;
    values_seen = 0;
    chars_seen  = 0;
  end

  // Convert one value and queue its characters, most significant digit first
  function automatic void queue_digit_chars(input logic [VALUE_W-1:0] v,
                                            input logic [BASE_W-1:0] b);
    logic [VALUE_W-1:0] quot;
    logic [VALUE_W-1:0] radix;
    logic [DIGIT_W-1:0] digits [MAX_DIGITS];
    int                 n;
    char_word_t         w;
    // saturate the radix into 2..16
    radix = VALUE_W'(b);
    if (b < RADIX_MIN) radix = VALUE_W'(RADIX_MIN);
    if (b > RADIX_MAX) radix = VALUE_W'(RADIX_MAX);
    quot = v;
    n = 0;
    // zero still yields a single digit
    do begin
      if (n < MAX_DIGITS) begin
        digits[n] = DIGIT_W'(quot % radix);
        n++;
      end
      quot = quot / radix;
    end while (quot != 0);
    for (int k = n - 1; k >= 0; k--) begin
      if (digits[k] < 4'd10) w.code = CHAR_W'(48) + CHAR_W'(digits[k]);
      else w.code = CHAR_W'(97) + CHAR_W'(digits[k]) - CHAR_W'(10);
      w.tail = (k == 0);
      expected_chars.push_back(w);
    end
  endfunction

  // Sample both channels at each edge, outside reset
  always @(posedge clk) begin : watch
    char_word_t w;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        queue_digit_chars(value, digit_base);
        values_seen++;
      end
      if (out_valid && !out_stall) begin
        chars_seen++;
        if (expected_chars.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected word char_code=%0d last=%0b",
                     $realtime, char_code, last);
          fail_count++;
        end else begin
          w = expected_chars.pop_front();
          if (char_code !== w.code || last !== w.tail) begin
            if (fail_count < 10)
              $display("%0t: mismatch char_code exp %0d got %0d, last exp %0b got %0b",
                       $realtime, w.code, char_code, w.tail, last);
            fail_count++;
          end
        end
      end
    end
    pending = expected_chars.size();
  end

endmodule

FILE: bench/tb.sv
// Testbench top for the radix digit converter: clock, reset, value/radix
// stimulus with random idling and stalls, and the verdict.
// Depends on itbd_pkg, int_to_base_digits and int_to_base_digits_checker.
`timescale 1ns / 1ps

module tb;
  import itbd_pkg::*;

  localparam logic [VALUE_W-1:0] VALUE_TOP = {VALUE_W{1'b1}};

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [VALUE_W-1:0] value = '0;
  logic [BASE_W-1:0]  digit_base = BASE_W'(10);
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CHAR_W-1:0]  char_code;
  logic               last;

  // no idling on either side while set
  logic               steady = 1'b0;

  int fail_count;
  int pending;
  int values_seen;
  int chars_seen;

  int_to_base_digits dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .digit_base (digit_base),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .char_code  (char_code),
    .last       (last)
  );

  int_to_base_digits_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value       (value),
    .digit_base  (digit_base),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .char_code   (char_code),
    .last        (last),
    .fail_count  (fail_count),
    .pending     (pending),
    .values_seen (values_seen),
    .chars_seen  (chars_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stall the output side about a quarter of the time
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 25);
  end

  // Offer one word, idling at random first, and hold it until taken
  task automatic send_word(input logic [VALUE_W-1:0] v, input logic [BASE_W-1:0] b);
    logic taken;
    while (!steady && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    value      <= v;
    digit_base <= b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
  endtask

  initial begin : stimulus
    logic [BASE_W-1:0]  b;
    logic [VALUE_W-1:0] v;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes of value, every radix edge, saturated radix codes
    send_word('0, BASE_W'(10));
    send_word('0, BASE_W'(2));
    send_word(VALUE_TOP, BASE_W'(2));
    send_word(VALUE_TOP, BASE_W'(16));
    send_word(VALUE_TOP, BASE_W'(10));
    send_word(VALUE_TOP, BASE_W'(3));
    send_word(VALUE_W'(1), BASE_W'(2));
    send_word(VALUE_W'(15), BASE_W'(16));
    send_word(VALUE_W'(10), BASE_W'(16));
    send_word(VALUE_W'(9), BASE_W'(10));
    send_word(VALUE_W'(5), BASE_W'(0));
    send_word(VALUE_W'(6), BASE_W'(1));
    send_word(VALUE_W'(32'h00ab_cdef), BASE_W'(17));
    send_word(VALUE_W'(32'h00ab_cdef), BASE_W'(31));
    send_word(VALUE_W'(1000), BASE_W'(7));
    send_word(VALUE_TOP, BASE_W'(11));
    send_word(VALUE_W'(32'h5555_5555), BASE_W'(5));
    send_word(VALUE_W'(32'h2aaa_aaaa), BASE_W'(13));
    send_word(VALUE_W'(32'h4000_0000), BASE_W'(4));

    // random values of random length, mostly legal radixes
    for (int i = 0; i < 350; i++) begin
      steady <= (i >= 120 && i < 190);
      if ($urandom_range(0, 99) < 80) b = BASE_W'($urandom_range(2, 16));
      else b = BASE_W'($urandom_range(0, 31));
      v = VALUE_W'($urandom >> $urandom_range(0, 32));
      send_word(v, b);
    end
    in_valid <= 1'b0;
    steady   <= 1'b0;

    // drain, then give stray words time to show up
    @(posedge clk);
    while (pending != 0) @(negedge clk);
    repeat (100) @(posedge clk);

    $display("converted %0d values into %0d characters, radix codes 0 to 31",
             values_seen, chars_seen);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d failures", fail_count);
      $display("tb failed");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #20_000_000;
    $display("timeout with %0d characters outstanding", pending);
    $display("tb failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/itbd_pkg.sv
rtl/itbd_divider.sv
rtl/itbd_digit_ram.sv
rtl/int_to_base_digits.sv
bench/int_to_base_digits_checker.sv
bench/tb.sv
